@@ hw/rtl/dnsq_pkg.sv @@
// Shared types and constants for the DNS question name parser.
// Used by every module of the block; depends on nothing.
package dnsq_pkg;

   // Fixed framing of the datagram
   localparam int HEADER_BYTES    = 12;
   localparam int MAX_LABELS      = 101;
   localparam int NAME_BUFFER_DEF = 256;

   localparam logic [7:0] LABEL_LIMIT = 8'd63;
   localparam logic [7:0] DOT_CHAR    = 8'h2E;

   // Result kinds
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // Parse phases
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_HEADER   = 3'd1,
      PH_LENGTH   = 3'd2,
      PH_LABEL    = 3'd3,
      PH_TYPE_HI  = 3'd4,
      PH_TYPE_LO  = 3'd5,
      PH_CLASS_HI = 3'd6,
      PH_CLASS_LO = 3'd7
   } phase_type;

   // Final status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LONG_LABEL = 2'd1,
      ST_OVERFLOW   = 2'd2
   } status_type;

   // One input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_type;

   // One result transaction
   typedef struct packed {
      logic        kind;
      logic [7:0]  name_char;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [1:0]  status;
      logic [7:0]  name_length;
   } rsp_type;

endpackage

@@ hw/rtl/dnsq_in_stage.sv @@
// Input register of the DNS question name parser.
// Holds one request transaction until the parse stage takes it; uses dnsq_pkg.
module dnsq_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dnsq_pkg::req_type req_item,
   input  logic             step,
   output logic             item_valid,
   output dnsq_pkg::req_type item
);
   import dnsq_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    accept;

   // Stall while a held transaction cannot move on
   assign req_stall = valid_ff && !step;
   assign accept    = req_valid && !req_stall;

   // Fill on accept, drain on step
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hw/rtl/dnsq_parse.sv @@
// Parse state machine of the DNS question name parser: header skip, label
// decode, type and class capture. Uses dnsq_pkg.
module dnsq_parse #(
   parameter int NAME_BUFFER = dnsq_pkg::NAME_BUFFER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dnsq_pkg::req_type item,
   output logic              res_valid,
   output dnsq_pkg::rsp_type res
);
   import dnsq_pkg::*;

   localparam int POS_W = $clog2(NAME_BUFFER);

   phase_type        phase_ff, phase_in, cur_phase;
   logic [3:0]       hdr_cnt_ff, hdr_cnt_in, cur_hdr_cnt;
   logic [5:0]       label_rem_ff, label_rem_in, cur_label_rem;
   logic [POS_W-1:0] char_pos_ff, char_pos_in, cur_char_pos;
   logic [6:0]       label_cnt_ff, label_cnt_in, cur_label_cnt;
   logic [7:0]       type_hi_ff, type_hi_in;
   logic [15:0]      type_ff, type_in;
   logic [7:0]       class_hi_ff, class_hi_in;
   logic [8:0]       pos_sum;
   logic [7:0]       b;

   assign b = item.data_byte;

   // Start restarts the parse, whatever the phase
   always_comb begin
      if (item.start_req) begin
         cur_phase     = PH_HEADER;
         cur_hdr_cnt   = '0;
         cur_label_rem = '0;
         cur_char_pos  = '0;
         cur_label_cnt = '0;
      end else begin
         cur_phase     = phase_ff;
         cur_hdr_cnt   = hdr_cnt_ff;
         cur_label_rem = label_rem_ff;
         cur_char_pos  = char_pos_ff;
         cur_label_cnt = label_cnt_ff;
      end
   end

   assign pos_sum = 9'(cur_char_pos) + 9'(b) + 9'd1;

   // Next state and result for the current byte
   always_comb begin
      phase_in     = cur_phase;
      hdr_cnt_in   = cur_hdr_cnt;
      label_rem_in = cur_label_rem;
      char_pos_in  = cur_char_pos;
      label_cnt_in = cur_label_cnt;
      type_hi_in   = type_hi_ff;
      type_in      = type_ff;
      class_hi_in  = class_hi_ff;
      res_valid    = 1'b0;
      res          = '0;
      case (cur_phase)
         PH_HEADER: begin
            hdr_cnt_in = cur_hdr_cnt + 4'd1;
            if (hdr_cnt_in >= 4'(HEADER_BYTES)) begin
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (cur_label_cnt >= 7'(MAX_LABELS)) begin
               // label limit: this byte is the type high byte
               type_hi_in = b;
               phase_in   = PH_TYPE_LO;
            end else if (b == 8'd0) begin
               phase_in = PH_TYPE_HI;
            end else if (b > LABEL_LIMIT) begin
               phase_in       = PH_IDLE;
               res_valid      = 1'b1;
               res.kind       = KIND_FINAL;
               res.status     = ST_LONG_LABEL;
            end else if (pos_sum >= 9'(NAME_BUFFER)) begin
               phase_in       = PH_IDLE;
               res_valid      = 1'b1;
               res.kind       = KIND_FINAL;
               res.status     = ST_OVERFLOW;
            end else begin
               label_cnt_in = cur_label_cnt + 7'd1;
               label_rem_in = b[5:0];
               char_pos_in  = pos_sum[POS_W-1:0];
               phase_in     = PH_LABEL;
               // dot between labels, none before the first
               if (cur_char_pos != '0) begin
                  res_valid     = 1'b1;
                  res.kind      = KIND_CHAR;
                  res.name_char = DOT_CHAR;
               end
            end
         end
         PH_LABEL: begin
            label_rem_in = cur_label_rem - 6'd1;
            if (label_rem_in == 6'd0) begin
               phase_in = PH_LENGTH;
            end
            res_valid     = 1'b1;
            res.kind      = KIND_CHAR;
            res.name_char = b;
         end
         PH_TYPE_HI: begin
            type_hi_in = b;
            phase_in   = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            type_in  = {type_hi_ff, b};
            phase_in = PH_CLASS_HI;
         end
         PH_CLASS_HI: begin
            class_hi_in = b;
            phase_in    = PH_CLASS_LO;
         end
         PH_CLASS_LO: begin
            phase_in        = PH_IDLE;
            res_valid       = 1'b1;
            res.kind        = KIND_FINAL;
            res.query_type  = type_ff;
            res.query_class = {class_hi_ff, b};
            res.status      = ST_OK;
            if (cur_char_pos != '0) begin
               res.name_length = 8'(cur_char_pos - POS_W'(1));
            end
         end
         default: begin
            // idle: drop bytes until the next start
         end
      endcase
   end

   // Advance control state on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_cnt_ff   <= '0;
         label_rem_ff <= '0;
         char_pos_ff  <= '0;
         label_cnt_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         label_rem_ff <= label_rem_in;
         char_pos_ff  <= char_pos_in;
         label_cnt_ff <= label_cnt_in;
      end
   end

   // Type and class bytes are always written before they are read
   always_ff @(posedge clock) begin
      if (step) begin
         type_hi_ff  <= type_hi_in;
         type_ff     <= type_in;
         class_hi_ff <= class_hi_in;
      end
   end

`ifndef ASSERT_OFF
   a_char_ok_status: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_CHAR) |-> (res.status == ST_OK))
      else $error("character result carries a nonzero status");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) && !item.start_req |-> !res_valid)
      else $error("result produced while idle");

   a_pos_in_buffer: assert property (@(posedge clock) disable iff (reset)
      9'(char_pos_ff) < 9'(NAME_BUFFER))
      else $error("name position beyond name buffer");

   a_label_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LABEL) |-> (label_rem_ff != 6'd0))
      else $error("label phase with no bytes remaining");
`endif

endmodule

@@ hw/rtl/dnsq_out_stage.sv @@
// Result register of the DNS question name parser.
// Holds one response transaction until the receiver takes it; uses dnsq_pkg.
module dnsq_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dnsq_pkg::rsp_type res,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dnsq_pkg::rsp_type rsp_item
);
   import dnsq_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   // Free when empty or being taken this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture result on load
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ hw/rtl/dns_question_name_parser.sv @@
// Top level of the DNS question name parser: input register, parse stage,
// result register. Depends on dnsq_pkg, dnsq_in_stage, dnsq_parse, dnsq_out_stage.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data_byte, req_start_req
//   rsp      out        rsp_valid / rsp_stall   rsp_kind, rsp_name_char, rsp_query_type,
//                                               rsp_query_class, rsp_status, rsp_name_length
//
// One byte per cycle sustained while rsp_stall is low; a byte is held in the input register
// and its result in the result register before the result shows on the rsp ports.
// Reset is synchronous and active high; it empties both registers and idles the parse.
// A stalled result holds the parse stage only when the next byte would also produce one;
// bytes that produce nothing keep moving, and req_stall rises only once the input
// register is full and blocked.
module dns_question_name_parser #(
   parameter int NAME_BUFFER = dnsq_pkg::NAME_BUFFER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_name_char,
   output logic [15:0] rsp_query_type,
   output logic [15:0] rsp_query_class,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_name_length
);
   import dnsq_pkg::*;

   req_type req_item, item;
   rsp_type res, rsp_item;
   logic    item_valid, res_valid, out_free, step, load;

   assign req_item = '{data_byte: req_data_byte, start_req: req_start_req};

   // Advance the held byte when its result, if any, has room
   assign step = item_valid && (out_free || !res_valid);
   assign load = step && res_valid;

   dnsq_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   dnsq_parse #(
      .NAME_BUFFER (NAME_BUFFER)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   dnsq_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind        = rsp_item.kind;
   assign rsp_name_char   = rsp_item.name_char;
   assign rsp_query_type  = rsp_item.query_type;
   assign rsp_query_class = rsp_item.query_class;
   assign rsp_status      = rsp_item.status;
   assign rsp_name_length = rsp_item.name_length;

endmodule
